/* rtl/bmf_pkg.sv */
// shared types and constants of the box mean filter
// no dependencies
package bmf_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_WINDOW = 31;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 13;
    localparam int SLOT_W   = 6;
    localparam int ROW_W    = 16;
    localparam int OCOL_W   = 12;
    localparam int WIN_W    = 5;
    localparam int CS_W     = 13;
    localparam int WS_W     = 18;
    localparam int FRAC     = 23;
    localparam int FAC_W    = 24;
    localparam int MN_W     = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [FAC_W-1:0] FACTOR_RESET = 24'd932067;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS  = 4'd3;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              first_row;
        logic              sub_old;
        logic              first_col;
        logic              sub_tap;
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  centre_row;
        logic [OCOL_W-1:0] centre_col;
    } bmf_item_t;

    typedef struct packed {
        logic [WIN_W-1:0] win_cols;
        logic [FAC_W-1:0] factor;
    } bmf_setup_t;

endpackage

/* rtl/bmf_if.sv */
// channel interfaces: pixel input, result output, configuration writes
// depends on bmf_pkg
interface bmf_pixel_if;
    import bmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface bmf_result_if;
    import bmf_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  mean_value;
    logic [ROW_W-1:0]  centre_row;
    logic [OCOL_W-1:0] centre_col;
    logic              frame_last;
    modport source (output valid, output mean_value, output centre_row, output centre_col,
                    output frame_last, input ready);
    modport sink (input valid, input mean_value, input centre_row, input centre_col,
                  input frame_last, output ready);
endinterface

interface bmf_cfg_if;
    import bmf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/box_mean_filter_column_sums_core.sv */
// Box mean filter over a raster pixel stream, one pixel per clock sustained while the output
// is not stalled and no mean factor is being rebuilt. A pixel passes through a two-entry
// queue, then a four-stage back end (memory read, column sum, window sum, multiply into the
// result register); a stalled output holds the whole back end and the queue fills. After any
// register write the mean factor is rebuilt by a radix-2 divider, during which no pixel is
// taken. Border pixels with an incomplete window give no result.
// depends on bmf_pkg, bmf_if, bmf_front, bmf_queue, bmf_back
module box_mean_filter_column_sums_core
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic         clk,
    input  logic         rst_n,
    bmf_pixel_if.sink    pix,
    bmf_cfg_if.sink      cfg,
    bmf_result_if.source res
);

    logic       push, q_full, q_valid, pop, busy;
    bmf_item_t  push_item, pop_item;
    bmf_setup_t setup;

    bmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push),
        .item   (push_item),
        .setup  (setup),
        .busy   (busy)
    );

    bmf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    bmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .pop     (pop),
        .setup   (setup),
        .res     (res)
    );

    a_cfg_stalls_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && (cfg.index == REG_IMAGE_WIDTH
         || cfg.index == REG_IMAGE_HEIGHT || cfg.index == REG_WINDOW_COLS
         || cfg.index == REG_WINDOW_ROWS)) |=> !pix.ready)
        else $error("pixel taken while mean factor is rebuilt");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("queue overrun");

    a_busy_blocks_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(pix.valid && pix.ready))
        else $error("transaction accepted during divide");

endmodule

/* rtl/bmf_front.sv */
// front end: configuration registers, mean factor divider, raster counters
// depends on bmf_pkg, bmf_if
module bmf_front
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic              clk,
    input  logic              rst_n,
    bmf_pixel_if.sink         pix,
    bmf_cfg_if.sink           cfg,
    input  logic              q_full,
    output logic              push,
    output bmf_item_t         item,
    output bmf_setup_t        setup,
    output logic              busy
);

    localparam int ODD_CAP = ((MAX_WINDOW - 1) / 2) * 2 + 1;

    logic [12:0]       width_reg, width_next;
    logic [ROW_W-1:0]  height_reg, height_next;
    logic [WIN_W-1:0]  cols_reg, cols_next;
    logic [WIN_W-1:0]  rows_reg, rows_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              busy_reg, busy_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [FAC_W-1:0]  quo_reg, quo_next;
    logic [MN_W:0]     rem_reg, rem_next;
    logic [FAC_W-1:0]  factor_reg, factor_next;

    logic              cfg_write;
    logic              accept;
    logic [WIN_W-1:0]  m, n;
    logic [MN_W-1:0]   mn;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic [MN_W:0]     trial;
    logic              ge;

    function automatic logic [WIN_W-1:0] odd_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] w;
        w = v | WIN_W'(1);
        return ({1'b0, w} > (WIN_W + 1)'(ODD_CAP)) ? WIN_W'(ODD_CAP) : w;
    endfunction

    assign m  = odd_win(cols_reg);
    assign n  = odd_win(rows_reg);
    assign mn = MN_W'(m) * MN_W'(n);

    always_comb
    begin
        if (width_reg == 13'd0)
        begin
            last_col = '0;
        end
        else if ({1'b0, width_reg} > 14'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(width_reg - 13'd1);
        end
        last_row = (height_reg == '0) ? '0 : height_reg - ROW_W'(1);
    end

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && (cfg.index == REG_IMAGE_WIDTH
                        || cfg.index == REG_IMAGE_HEIGHT || cfg.index == REG_WINDOW_COLS
                        || cfg.index == REG_WINDOW_ROWS);
    assign pix.ready  = !busy_reg && !q_full;
    assign accept     = pix.valid && pix.ready;
    assign push       = accept;
    assign busy       = busy_reg;
    assign setup.win_cols = m;
    assign setup.factor   = factor_reg;

    always_comb
    begin
        item.pixel      = pix.pixel;
        item.col        = col_reg;
        item.slot       = slot_reg;
        item.first_row  = (row_reg == '0);
        item.sub_old    = (row_reg >= ROW_W'(n));
        item.first_col  = (col_reg == '0);
        item.sub_tap    = (col_reg >= COL_W'(m));
        item.emit       = (row_reg >= ROW_W'(n) - ROW_W'(1)) && (col_reg >= COL_W'(m) - COL_W'(1));
        item.last       = (row_reg == last_row) && (col_reg == last_col);
        item.centre_row = row_reg - ROW_W'(n >> 1);
        item.centre_col = OCOL_W'(col_reg - COL_W'(m >> 1));
    end

    assign trial = {rem_reg[MN_W-1:0], quo_reg[FAC_W-1]};
    assign ge    = trial >= {1'b0, mn};

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        factor_next = factor_reg;

        if (busy_reg)
        begin
            rem_next = ge ? trial - {1'b0, mn} : trial;
            quo_next = {quo_reg[FAC_W-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(FAC_W - 1))
            begin
                busy_next   = 1'b0;
                factor_next = quo_next;
            end
        end

        if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                if (row_reg == last_row)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    slot_next = (slot_reg + SLOT_W'(1) >= SLOT_W'(n)) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        if (cfg_write)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  width_next  = cfg.data[12:0];
                REG_IMAGE_HEIGHT: height_next = cfg.data[ROW_W-1:0];
                REG_WINDOW_COLS:  cols_next   = cfg.data[WIN_W-1:0];
                REG_WINDOW_ROWS:  rows_next   = cfg.data[WIN_W-1:0];
                default:          width_next  = width_reg;
            endcase
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = FAC_W'(1) << FRAC;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 16'd480;
            cols_reg   <= 5'd3;
            rows_reg   <= 5'd3;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            factor_reg <= FACTOR_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            factor_reg <= factor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

/* rtl/bmf_queue.sv */
// two-entry transaction queue between front and back end
// depends on bmf_pkg
module bmf_queue
    import bmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bmf_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output bmf_item_t pop_item
);

    bmf_item_t   slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_item  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/bmf_back.sv */
// back end: row store, column sums, running window sum, scaling, result register
// depends on bmf_pkg, bmf_if
module bmf_back
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  bmf_item_t  q_item,
    output logic       pop,
    input  bmf_setup_t setup,
    bmf_result_if.source res
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SW  = $clog2(MAX_WINDOW);
    localparam int RAW = $clog2(MAX_WINDOW * MAX_WIDTH);
    localparam int TW  = $clog2(MAX_WINDOW);

    logic [PIX_W-1:0] row_store [MAX_WINDOW * MAX_WIDTH];
    logic [CS_W-1:0]  col_sums [MAX_WIDTH];
    logic [CS_W-1:0]  line_reg [MAX_WINDOW];

    logic              en;
    logic [RAW-1:0]    rd_addr, wr_addr;

    logic              vb_reg, vc_reg, vd_reg;
    bmf_item_t         item_b_reg, item_c_reg, item_d_reg;
    logic [PIX_W-1:0]  rs_q_reg;
    logic [CS_W-1:0]   cs_q_reg;
    logic              fwd_pix_reg, fwd_cs_reg;
    logic [CS_W-1:0]   cs_c_reg;
    logic [WS_W-1:0]   ws_reg, ws_next;
    logic [WS_W-1:0]   ws_d_reg;
    logic [PIX_W-1:0]  old_pix;
    logic [CS_W-1:0]   col_val, cs_next, tap;
    logic [WS_W+FAC_W-1:0] prod;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  mean_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic [OCOL_W-1:0] ocol_reg;
    logic              olast_reg;

    assign en  = !out_valid_reg || res.ready;
    assign pop = en && q_valid;

    assign rd_addr = RAW'(q_item.slot[SW-1:0]) * RAW'(MAX_WIDTH) + RAW'(q_item.col[CW-1:0]);
    assign wr_addr = RAW'(item_b_reg.slot[SW-1:0]) * RAW'(MAX_WIDTH)
                     + RAW'(item_b_reg.col[CW-1:0]);

    // stage b: column sum over the last rows, bypassing a write in flight
    always_comb
    begin
        old_pix = fwd_pix_reg ? item_c_reg.pixel : rs_q_reg;
        col_val = fwd_cs_reg ? cs_c_reg : cs_q_reg;
        if (item_b_reg.first_row)
        begin
            cs_next = CS_W'(item_b_reg.pixel);
        end
        else
        begin
            cs_next = col_val + CS_W'(item_b_reg.pixel)
                      - (item_b_reg.sub_old ? CS_W'(old_pix) : CS_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_q_reg <= row_store[rd_addr];
            if (vb_reg)
            begin
                row_store[wr_addr] <= item_b_reg.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_q_reg <= col_sums[q_item.col[CW-1:0]];
            if (vb_reg)
            begin
                col_sums[item_b_reg.col[CW-1:0]] <= cs_next;
            end
        end
    end

    // stage c: running sum of the last column sums
    assign tap = line_reg[TW'(setup.win_cols - WIN_W'(1))];

    always_comb
    begin
        if (item_c_reg.first_col)
        begin
            ws_next = WS_W'(cs_c_reg);
        end
        else
        begin
            ws_next = ws_reg + WS_W'(cs_c_reg) - (item_c_reg.sub_tap ? WS_W'(tap) : WS_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vc_reg)
        begin
            line_reg[0] <= cs_c_reg;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign prod = WS_W'(ws_d_reg) * (WS_W+FAC_W)'(setup.factor);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_b_reg  <= q_item;
            fwd_pix_reg <= vb_reg && item_b_reg.col == q_item.col && item_b_reg.slot == q_item.slot;
            fwd_cs_reg  <= vb_reg && item_b_reg.col == q_item.col;
            item_c_reg  <= item_b_reg;
            cs_c_reg    <= cs_next;
            item_d_reg  <= item_c_reg;
            ws_d_reg    <= ws_next;
            mean_reg    <= prod[FRAC+PIX_W-1:FRAC];
            orow_reg    <= item_d_reg.centre_row;
            ocol_reg    <= item_d_reg.centre_col;
            olast_reg   <= item_d_reg.last;
            if (vc_reg)
            begin
                ws_reg <= ws_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg        <= q_valid;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg && item_c_reg.emit;
            out_valid_reg <= vd_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.mean_value = mean_reg;
    assign res.centre_row = orow_reg;
    assign res.centre_col = ocol_reg;
    assign res.frame_last = olast_reg;

endmodule
